// File: rtl/dkt_pkg.sv
// shared types, constants and saturating helpers of the depth tracker
`timescale 1ns / 1ps
`default_nettype none
package dkt_pkg;

  // item kinds
  localparam logic [1:0] KIND_PREDICT = 2'd0;
  localparam logic [1:0] KIND_MEASURE = 2'd1;
  localparam logic [1:0] KIND_RESET   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] IDX_PROC_Q   = 3'd0;
  localparam logic [2:0] IDX_MEAS_R   = 3'd1;
  localparam logic [2:0] IDX_POS_STD  = 3'd2;
  localparam logic [2:0] IDX_VEL_STD  = 3'd3;
  localparam logic [2:0] IDX_MAX_MISS = 3'd4;

  // register reset values
  localparam logic [31:0] PROC_Q_RST   = 32'd65536;
  localparam logic [31:0] MEAS_R_RST   = 32'd65536;
  localparam logic [19:0] POS_STD_RST  = 20'd1600;
  localparam logic [19:0] VEL_STD_RST  = 20'd16000;
  localparam logic [7:0]  MAX_MISS_RST = 8'd10;

  // covariance diagonal after reset: std^2 in Q.16
  localparam logic [63:0] COV_PP_RST = 64'd2560000 << 16;
  localparam logic [63:0] COV_VV_RST = 64'd256000000 << 16;

  // microseconds to Q32 seconds: 2^32 = DT_WHOLE * 10^6 + DT_FRAC
  localparam logic [12:0] DT_WHOLE = 13'd4294;
  localparam logic [39:0] DT_FRAC  = 40'd967296;
  localparam logic [39:0] DT_ROUND = 40'd500000;
  // ceil(2^60 / 10^6), exact floor quotient for a dividend below 2^40
  localparam logic signed [63:0] DT_RECIP = 64'sd1152921504607;
  // multiplier shift for the reciprocal product, the last 42 bits are dropped after
  localparam logic [5:0] DT_RECIP_SH = 6'd18;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S48_MIN = 64'shFFFF_8000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_PCHK, S_DT, S_P_DEP, S_P_PP, S_P_V, S_P_PP2, S_P_T2, S_P_T3,
    S_P_T4, S_P_QPP, S_P_QX, S_P_QVV, S_MISS, S_MEAS, S_K0, S_K1, S_U_DEP,
    S_U_VEL, S_U_VP, S_U_VV, S_U_PP, S_U_PV, S_CLEAR, S_SEED, S_LD_PP,
    S_LD_VV, S_OUT
  } state_t;

  // request to the multiply unit: round(a*b / 2^sh)
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
  } mul_req_t;

  // request to the divide unit: trunc(num / den), signed by neg
  typedef struct packed {
    logic        start;
    logic [95:0] num;
    logic [63:0] den;
    logic        neg;
  } div_req_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > S48_MAX) return S48_MAX[47:0];
    if (v < S48_MIN) return S48_MIN[47:0];
    return v[47:0];
  endfunction

  // round to 1/16 mm, ties up, saturated to 32 bits
  function automatic logic [31:0] report32(input logic signed [47:0] x);
    logic signed [49:0] v;
    logic signed [49:0] r;
    v = {{2{x[47]}}, x} + 50'sd32768;
    r = v >>> 16;
    if (r > 50'sd2147483647) return 32'h7FFF_FFFF;
    if (r < -50'sd2147483648) return 32'h8000_0000;
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/dkt_chan_if.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps
`default_nettype none
interface dkt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [19:0] measured_depth;
  logic [19:0] elapsed_time;
  modport source (output valid, kind, measured_depth, elapsed_time, input ready);
  modport sink (input valid, kind, measured_depth, elapsed_time, output ready);
endinterface

interface dkt_out_if;
  logic               valid;
  logic               ready;
  logic               tracking;
  logic signed [31:0] depth_estimate;
  logic signed [31:0] velocity_estimate;
  modport source (output valid, tracking, depth_estimate, velocity_estimate,
                  input ready);
  modport sink (input valid, tracking, depth_estimate, velocity_estimate,
                output ready);
endinterface
`default_nettype wire

// File: rtl/dkt_mul.sv
// multi-cycle 64x64 rounding multiplier built on one 32x32 product
`timescale 1ns / 1ps
`default_nettype none
module dkt_mul
  import dkt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mul_req_t           req,
  output logic                    done,
  output logic signed [63:0]      res
);

  logic         busy_r, done_r, neg_r;
  logic [2:0]   cnt_r;
  logic [63:0]  ma_r, mb_r;
  logic [5:0]   sh_r;
  logic [127:0] acc_r;
  logic signed [63:0] res_r;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] shifted;
  logic [127:0] half_lsb;

  // partial product order: a0*b0, a0*b1, a1*b0, a1*b1
  assign a_half = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_half = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp     = 64'(a_half) * 64'(b_half);
  assign pos    = 2'(cnt_r[1]) + 2'(cnt_r[0]);
  assign half_lsb = 128'd1 << (sh_r - 6'd1);
  assign shifted  = acc_r >> sh_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd5);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd5) busy_r <= 1'b0;
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      ma_r  <= mag64(req.a);
      mb_r  <= mag64(req.b);
      neg_r <= req.a[63] ^ req.b[63];
      sh_r  <= req.sh;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        acc_r <= acc_r + ({64'd0, pp} << {pos, 5'd0});
      end else if (cnt_r == 3'd4) begin
        acc_r <= acc_r + half_lsb;
      end else begin
        if (shifted[127:63] != '0) res_r <= neg_r ? S64_MIN : S64_MAX;
        else res_r <= neg_r ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// File: rtl/dkt_div.sv
// restoring divider, one quotient bit per cycle, saturated signed result
`timescale 1ns / 1ps
`default_nettype none
module dkt_div
  import dkt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire div_req_t      req,
  output logic               done,
  output logic signed [63:0] res
);

  localparam int NumW = 96;
  localparam logic [6:0] LastStep = 7'(NumW);

  logic         busy_r, done_r, neg_r;
  logic [6:0]   cnt_r;
  logic [95:0]  n_r;
  logic [63:0]  den_r, rem_r;
  logic signed [63:0] res_r;

  logic [64:0]  trial;
  logic         ge;

  assign trial = {rem_r, n_r[95]};
  assign ge    = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LastStep);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LastStep) busy_r <= 1'b0;
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  // quotient bits shift into the numerator register
  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= req.num;
      den_r <= req.den;
      neg_r <= req.neg;
      rem_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < LastStep) begin
        rem_r <= ge ? 64'(trial - {1'b0, den_r}) : trial[63:0];
        n_r   <= {n_r[94:0], ge};
      end else begin
        if (n_r[95:63] != '0) res_r <= neg_r ? S64_MIN : S64_MAX;
        else res_r <= neg_r ? -$signed(n_r[63:0]) : $signed(n_r[63:0]);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// File: rtl/depth_kalman_tracker_core.sv
// depth tracker top level: sequencer, filter state and configuration
// work per item: a tracked predict runs 11 products on the shared
//   multiplier, one a reciprocal for dt; a measure update adds two
//   gain divides and 6 products
// throughput: one item at a time, ready only while the sequencer is idle
// reset: synchronous rst_n restores register defaults and clears the filter
`timescale 1ns / 1ps
`default_nettype none
module depth_kalman_tracker_core
  import dkt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  dkt_in_if.sink           in_ch,
  dkt_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration
  logic [31:0] proc_q_r, meas_r_r;
  logic [19:0] pos_std_r, vel_std_r;
  logic [7:0]  max_miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_q_r   <= PROC_Q_RST;
      meas_r_r   <= MEAS_R_RST;
      pos_std_r  <= POS_STD_RST;
      vel_std_r  <= VEL_STD_RST;
      max_miss_r <= MAX_MISS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        IDX_PROC_Q:   proc_q_r   <= cfg_data;
        IDX_MEAS_R:   meas_r_r   <= cfg_data;
        IDX_POS_STD:  pos_std_r  <= cfg_data[19:0];
        IDX_VEL_STD:  vel_std_r  <= cfg_data[19:0];
        IDX_MAX_MISS: max_miss_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // state
  state_t state_r, state_nxt;
  logic pend_r, pend_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [19:0] meas_r, meas_nxt, us_r, us_nxt;
  logic signed [47:0] dep_r, dep_nxt, vel_r, vel_nxt;
  logic signed [63:0] pp_r, pp_nxt, pv_r, pv_nxt, vp_r, vp_nxt, vv_r, vv_nxt;
  logic trk_r, trk_nxt;
  logic [8:0] miss_r, miss_nxt;
  logic signed [63:0] dt_r, dt_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt;
  logic signed [63:0] s_r, s_nxt, k0_r, k0_nxt, k1_r, k1_nxt, inn_r, inn_nxt;
  logic out_valid_r, out_valid_nxt, out_trk_r, out_trk_nxt;
  logic [31:0] out_dep_r, out_dep_nxt, out_vel_r, out_vel_nxt;

  mul_req_t mreq;
  div_req_t dreq;
  logic mul_done, div_done, op_mul, op_div, op_done;
  logic signed [63:0] mul_res, div_res;

  dkt_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mul_done), .res(mul_res));
  dkt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(div_done), .res(div_res));

  // helper values
  logic in_xfer, out_free, miss_over;
  logic signed [63:0] dep64, vel64, q64, s_calc, z64, m;
  logic [8:0]  miss_inc;
  logic [39:0] sq;
  logic [39:0] dt_frac_num;
  logic [32:0] dt_base;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign dep64     = {{16{dep_r[47]}}, dep_r};
  assign vel64     = {{16{vel_r[47]}}, vel_r};
  assign q64       = (proc_q_r == '0) ? 64'sd1 : $signed({32'd0, proc_q_r});
  assign s_calc    = sadd64(pp_r, $signed({24'd0,
                      (meas_r_r == '0) ? 32'd1 : meas_r_r, 8'd0}));
  assign z64       = $signed({28'd0, meas_r, 16'd0});
  assign miss_inc  = miss_r + 9'd1;
  assign miss_over = miss_inc > {1'b0, max_miss_r};
  assign sq        = (state_r == S_LD_VV) ? 40'(vel_std_r) * 40'(vel_std_r)
                                          : 40'(pos_std_r) * 40'(pos_std_r);
  // dt split: us * DT_WHOLE plus round-biased remainder term over 10^6
  assign dt_frac_num = 40'(us_r) * DT_FRAC + DT_ROUND;
  assign dt_base     = 33'(us_r) * 33'(DT_WHOLE);
  assign m         = mul_res;
  assign op_done   = (op_mul && mul_done) || (op_div && div_done);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.kind == KIND_PREDICT || in_ch.kind == KIND_MEASURE) state_nxt = S_PCHK;
          else if (in_ch.kind == KIND_RESET) state_nxt = S_CLEAR;
          else state_nxt = S_OUT;
        end
      end
      S_PCHK: begin
        if (trk_r && us_r != '0) state_nxt = S_DT;
        else state_nxt = (kind_r == KIND_MEASURE) ? S_MEAS : S_OUT;
      end
      S_DT:    if (op_done) state_nxt = S_P_DEP;
      S_P_DEP: if (op_done) state_nxt = S_P_PP;
      S_P_PP:  if (op_done) state_nxt = S_P_V;
      S_P_V:   if (op_done) state_nxt = S_P_PP2;
      S_P_PP2: if (op_done) state_nxt = S_P_T2;
      S_P_T2:  if (op_done) state_nxt = S_P_T3;
      S_P_T3:  if (op_done) state_nxt = S_P_T4;
      S_P_T4:  if (op_done) state_nxt = S_P_QPP;
      S_P_QPP: if (op_done) state_nxt = S_P_QX;
      S_P_QX:  if (op_done) state_nxt = S_P_QVV;
      S_P_QVV: if (op_done) state_nxt = S_MISS;
      S_MISS: begin
        if (miss_over) state_nxt = S_CLEAR;
        else state_nxt = (kind_r == KIND_MEASURE) ? S_MEAS : S_OUT;
      end
      S_MEAS: begin
        if (!trk_r) state_nxt = S_SEED;
        else if (s_calc <= 0) state_nxt = S_OUT;
        else state_nxt = S_K0;
      end
      S_K0:    if (op_done) state_nxt = S_K1;
      S_K1:    if (op_done) state_nxt = S_U_DEP;
      S_U_DEP: if (op_done) state_nxt = S_U_VEL;
      S_U_VEL: if (op_done) state_nxt = S_U_VP;
      S_U_VP:  if (op_done) state_nxt = S_U_VV;
      S_U_VV:  if (op_done) state_nxt = S_U_PP;
      S_U_PP:  if (op_done) state_nxt = S_U_PV;
      S_U_PV:  if (op_done) state_nxt = S_OUT;
      S_CLEAR: state_nxt = S_LD_PP;
      S_SEED:  state_nxt = S_LD_PP;
      S_LD_PP: state_nxt = S_LD_VV;
      S_LD_VV: state_nxt = (kind_r == KIND_MEASURE && !trk_r) ? S_MEAS : S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // operands and register updates
  always_comb begin
    kind_nxt = kind_r; meas_nxt = meas_r; us_nxt = us_r;
    dep_nxt = dep_r; vel_nxt = vel_r;
    pp_nxt = pp_r; pv_nxt = pv_r; vp_nxt = vp_r; vv_nxt = vv_r;
    trk_nxt = trk_r; miss_nxt = miss_r;
    dt_nxt = dt_r; t2_nxt = t2_r; t3_nxt = t3_r; t4_nxt = t4_r;
    s_nxt = s_r; k0_nxt = k0_r; k1_nxt = k1_r; inn_nxt = inn_r;
    out_trk_nxt = out_trk_r; out_dep_nxt = out_dep_r; out_vel_nxt = out_vel_r;
    op_mul = 1'b0; op_div = 1'b0;
    mreq = '0; mreq.sh = 6'd32;
    dreq = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_ch.kind;
          meas_nxt = in_ch.measured_depth;
          us_nxt   = in_ch.elapsed_time;
        end
      end
      // remainder term divided by 10^6 through a reciprocal product
      S_DT: begin
        op_mul = 1'b1; mreq.a = $signed({24'd0, dt_frac_num}); mreq.b = DT_RECIP;
        mreq.sh = DT_RECIP_SH;
        if (mul_done) dt_nxt = $signed({31'd0, dt_base}) + $signed({42'd0, m[63:42]});
      end
      S_P_DEP: begin
        op_mul = 1'b1; mreq.a = vel64; mreq.b = dt_r;
        if (mul_done) dep_nxt = sat48(sadd64(dep64, m));
      end
      S_P_PP: begin
        op_mul = 1'b1; mreq.a = dt_r; mreq.b = vp_r;
        if (mul_done) pp_nxt = sadd64(pp_r, m);
      end
      S_P_V: begin
        op_mul = 1'b1; mreq.a = dt_r; mreq.b = vv_r;
        if (mul_done) begin
          pv_nxt = sadd64(pv_r, m);
          vp_nxt = sadd64(vp_r, m);
        end
      end
      S_P_PP2: begin
        op_mul = 1'b1; mreq.a = dt_r; mreq.b = pv_r;
        if (mul_done) pp_nxt = sadd64(pp_r, m);
      end
      S_P_T2: begin
        op_mul = 1'b1; mreq.a = dt_r; mreq.b = dt_r;
        if (mul_done) t2_nxt = m;
      end
      S_P_T3: begin
        op_mul = 1'b1; mreq.a = t2_r; mreq.b = dt_r;
        if (mul_done) t3_nxt = m;
      end
      S_P_T4: begin
        op_mul = 1'b1; mreq.a = t3_r; mreq.b = dt_r;
        if (mul_done) t4_nxt = m;
      end
      S_P_QPP: begin
        op_mul = 1'b1; mreq.a = q64; mreq.b = t4_r; mreq.sh = 6'd26;
        if (mul_done) pp_nxt = sadd64(pp_r, m);
      end
      S_P_QX: begin
        op_mul = 1'b1; mreq.a = q64; mreq.b = t3_r; mreq.sh = 6'd25;
        if (mul_done) begin
          pv_nxt = sadd64(pv_r, m);
          vp_nxt = sadd64(vp_r, m);
        end
      end
      S_P_QVV: begin
        op_mul = 1'b1; mreq.a = q64; mreq.b = t2_r; mreq.sh = 6'd24;
        if (mul_done) vv_nxt = sadd64(vv_r, m);
      end
      S_MISS: miss_nxt = miss_inc;
      S_MEAS: begin
        if (trk_r) begin
          miss_nxt = '0;
          s_nxt    = s_calc;
          inn_nxt  = z64 - dep64;
        end
      end
      S_K0: begin
        op_div = 1'b1;
        dreq.num = {mag64(pp_r), 32'd0}; dreq.den = s_r; dreq.neg = pp_r[63];
        if (div_done) k0_nxt = div_res;
      end
      S_K1: begin
        op_div = 1'b1;
        dreq.num = {mag64(vp_r), 32'd0}; dreq.den = s_r; dreq.neg = vp_r[63];
        if (div_done) k1_nxt = div_res;
      end
      S_U_DEP: begin
        op_mul = 1'b1; mreq.a = k0_r; mreq.b = inn_r;
        if (mul_done) dep_nxt = sat48(sadd64(dep64, m));
      end
      S_U_VEL: begin
        op_mul = 1'b1; mreq.a = k1_r; mreq.b = inn_r;
        if (mul_done) vel_nxt = sat48(sadd64(vel64, m));
      end
      // cross terms first, they need the old pp and pv
      S_U_VP: begin
        op_mul = 1'b1; mreq.a = k1_r; mreq.b = pp_r;
        if (mul_done) vp_nxt = ssub64(vp_r, m);
      end
      S_U_VV: begin
        op_mul = 1'b1; mreq.a = k1_r; mreq.b = pv_r;
        if (mul_done) vv_nxt = ssub64(vv_r, m);
      end
      S_U_PP: begin
        op_mul = 1'b1; mreq.a = k0_r; mreq.b = pp_r;
        if (mul_done) pp_nxt = ssub64(pp_r, m);
      end
      S_U_PV: begin
        op_mul = 1'b1; mreq.a = k0_r; mreq.b = pv_r;
        if (mul_done) pv_nxt = ssub64(pv_r, m);
      end
      S_CLEAR: begin
        dep_nxt = '0; vel_nxt = '0; trk_nxt = 1'b0; miss_nxt = '0;
      end
      S_SEED: begin
        dep_nxt = z64[47:0]; vel_nxt = '0; trk_nxt = 1'b1; miss_nxt = '0;
      end
      S_LD_PP: begin
        pp_nxt = $signed({8'd0, sq, 16'd0});
        pv_nxt = '0;
        vp_nxt = '0;
      end
      S_LD_VV: vv_nxt = $signed({8'd0, sq, 16'd0});
      S_OUT: begin
        if (out_free) begin
          out_trk_nxt = trk_r;
          out_dep_nxt = trk_r ? report32(dep_r) : 32'd0;
          out_vel_nxt = trk_r ? report32(vel_r) : 32'd0;
        end
      end
      default: ;
    endcase
    mreq.start = op_mul && !pend_r;
    dreq.start = op_div && !pend_r;
    if (op_mul || op_div) pend_nxt = pend_r ? !op_done : 1'b1;
    else pend_nxt = 1'b0;
    out_valid_nxt = (out_valid_r && !out_ch.ready) || (state_r == S_OUT && out_free);
  end

  // control and filter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dep_r       <= '0;
      vel_r       <= '0;
      pp_r        <= $signed(COV_PP_RST);
      pv_r        <= '0;
      vp_r        <= '0;
      vv_r        <= $signed(COV_VV_RST);
      trk_r       <= 1'b0;
      miss_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      dep_r       <= dep_nxt;
      vel_r       <= vel_nxt;
      pp_r        <= pp_nxt;
      pv_r        <= pv_nxt;
      vp_r        <= vp_nxt;
      vv_r        <= vv_nxt;
      trk_r       <= trk_nxt;
      miss_r      <= miss_nxt;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; meas_r <= meas_nxt; us_r <= us_nxt;
    dt_r <= dt_nxt; t2_r <= t2_nxt; t3_r <= t3_nxt; t4_r <= t4_nxt;
    s_r <= s_nxt; k0_r <= k0_nxt; k1_r <= k1_nxt; inn_r <= inn_nxt;
    out_trk_r <= out_trk_nxt; out_dep_r <= out_dep_nxt; out_vel_r <= out_vel_nxt;
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.tracking          = out_trk_r;
  assign out_ch.depth_estimate    = $signed(out_dep_r);
  assign out_ch.velocity_estimate = $signed(out_vel_r);

endmodule
`default_nettype wire
